// ----- sv/dcrmc_pkg.sv -----
// package: types, constants and helpers for the duty-cycled radio link controller
package dcrmc_pkg;

    localparam int unsigned HOLD_TICKS_DEF    = 10;
    localparam int unsigned MAX_JOB_TICKS_DEF = 5000;
    localparam int unsigned JITTER_TICKS_DEF  = 1;
    localparam int unsigned MAP_SIZE          = 256;
    localparam int unsigned MAP_AW            = $clog2(MAP_SIZE);
    localparam int unsigned QDEPTH            = 2;
    localparam int unsigned DIV_STEPS         = 32;

    typedef enum logic [1:0] {
        M_RX   = 2'd0,
        M_LOOK = 2'd1,
        M_TX   = 2'd2,
        M_IDLE = 2'd3
    } t_mac_mode;

    typedef enum logic [1:0] {
        IN_TICK = 2'd0,
        IN_REQ  = 2'd1,
        IN_IDLE = 2'd2,
        IN_NOP  = 2'd3
    } t_in_mode;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_DONE     = 2'd1,
        EV_REPLACED = 2'd2,
        EV_PREEMPT  = 2'd3
    } t_event;

    localparam logic [1:0] RX_NONE  = 2'd0;
    localparam logic [1:0] RX_FRAME = 2'd1;
    localparam logic [1:0] RX_CRC   = 2'd2;

    localparam logic [2:0] CFG_RX_EN   = 3'd0;
    localparam logic [2:0] CFG_RX_CONT = 3'd1;
    localparam logic [2:0] CFG_THRESH  = 3'd2;
    localparam logic [2:0] CFG_SHORT   = 3'd3;
    localparam logic [2:0] CFG_LONG    = 3'd4;
    localparam logic [2:0] CFG_OFF     = 3'd5;
    localparam logic [2:0] CFG_SLOT    = 3'd6;
    localparam logic [2:0] CFG_QUIET   = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_TICK,
        S_MARK,
        S_CLEAR,
        S_OUT
    } t_back_state;

    // one classified item as it sits in the queue
    typedef struct packed {
        t_in_mode    kind;
        logic [31:0] now;
        logic        awake;
        logic [1:0]  rx_event;
        logic        receiving;
        logic        header;
        logic [7:0]  hash;
        logic signed [7:0] strength;
        logic        rnd;
        logic        accepted;
        logic [3:0]  prio;
        logic [31:0] budget;
    } t_item;

    typedef struct packed {
        logic        radio_on;
        logic        send_now;
        logic        frame_delivered;
        logic [1:0]  event_code;
        logic        request_taken;
        logic [7:0]  sent_count;
        logic [7:0]  others_seen;
        logic        energy_latched;
        logic        busy_res;
    } t_result;

    function automatic logic [7:0] fold_id(input logic [31:0] id);
        fold_id = id[31:24] ^ id[23:16] ^ id[15:8] ^ id[7:0];
    endfunction

endpackage

// ----- sv/duty_cycled_radio_mac_controller.sv -----
// top level of the duty-cycled radio link controller
//
// Input channel: push/full. Each word is a time tick with radio status, a
// transmit request, a force-idle command or a no-op, chosen by i_mode.
// Result channel: empty/pop. Exactly one result word comes out for each
// input word, in order, held on the o_ ports while empty is low.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data write one register per
// cycle; write only while no word is in flight.
// A tick goes from the queue head through S_CLEAR (on listen entry only),
// S_MARK (seen-map lookup) and S_TICK (mode logic) to the result register.
// A taken transmit request runs the 32-step budget divider, others S_OUT.
// A two-entry input queue lets new words arrive while the back end works;
// the back end takes its next word only once the result register is empty
// or the receiver is popping the previous result.
// Reset is synchronous; afterwards the block is in receive mode with the
// seen-map clear and the control and configuration registers at their reset values.
// When the receiver stalls, the back end holds its next word and the input
// queue fills, raising full.
module duty_cycled_radio_mac_controller #(
    parameter int unsigned HOLD_TICKS    = dcrmc_pkg::HOLD_TICKS_DEF,
    parameter int unsigned MAX_JOB_TICKS = dcrmc_pkg::MAX_JOB_TICKS_DEF,
    parameter int unsigned JITTER_TICKS  = dcrmc_pkg::JITTER_TICKS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_mode,
    input  logic [31:0]        i_now,
    input  logic               i_radio_awake,
    input  logic [1:0]         i_rx_event,
    input  logic               i_receiving,
    input  logic               i_header_complete,
    input  logic [31:0]        i_sender_id,
    input  logic signed [7:0]  i_signal_strength,
    input  logic               i_random_bit,
    input  logic               i_send_accepted,
    input  logic [3:0]         i_priority_req,
    input  logic [31:0]        i_budget_ticks,
    output logic               empty,
    input  logic               pop,
    output logic               o_radio_on,
    output logic               o_send_now,
    output logic               o_frame_delivered,
    output logic [1:0]         o_event_code,
    output logic               o_request_taken,
    output logic [7:0]         o_sent_count,
    output logic [7:0]         o_others_seen,
    output logic               o_energy_latched,
    output logic               o_busy_res,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    logic               w_valid, w_take, w_rvalid;
    dcrmc_pkg::t_item   w_item;
    dcrmc_pkg::t_result w_res;

    dcrmc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .full        (full),
        .i_kind      (dcrmc_pkg::t_in_mode'(i_mode)),
        .i_now       (i_now),
        .i_awake     (i_radio_awake),
        .i_rx_event  (i_rx_event),
        .i_receiving (i_receiving),
        .i_header    (i_header_complete),
        .i_sender_id (i_sender_id),
        .i_strength  (i_signal_strength),
        .i_rnd       (i_random_bit),
        .i_accepted  (i_send_accepted),
        .i_prio      (i_priority_req),
        .i_budget    (i_budget_ticks),
        .o_valid     (w_valid),
        .o_item      (w_item),
        .i_take      (w_take)
    );

    dcrmc_back #(
        .HOLD_TICKS    (HOLD_TICKS),
        .MAX_JOB_TICKS (MAX_JOB_TICKS),
        .JITTER_TICKS  (JITTER_TICKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid),
        .i_item      (w_item),
        .o_take      (w_take),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (w_rvalid),
        .o_res       (w_res),
        .i_res_pop   (pop)
    );

    assign empty             = !w_rvalid;
    assign o_radio_on        = w_res.radio_on;
    assign o_send_now        = w_res.send_now;
    assign o_frame_delivered = w_res.frame_delivered;
    assign o_event_code      = w_res.event_code;
    assign o_request_taken   = w_res.request_taken;
    assign o_sent_count      = w_res.sent_count;
    assign o_others_seen     = w_res.others_seen;
    assign o_energy_latched  = w_res.energy_latched;
    assign o_busy_res        = w_res.busy_res;
endmodule

// ----- sv/dcrmc_front.sv -----
// front end: input queue that classifies items and folds sender ids
module dcrmc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 full,
    input  dcrmc_pkg::t_in_mode  i_kind,
    input  logic [31:0]          i_now,
    input  logic                 i_awake,
    input  logic [1:0]           i_rx_event,
    input  logic                 i_receiving,
    input  logic                 i_header,
    input  logic [31:0]          i_sender_id,
    input  logic signed [7:0]    i_strength,
    input  logic                 i_rnd,
    input  logic                 i_accepted,
    input  logic [3:0]           i_prio,
    input  logic [31:0]          i_budget,
    output logic                 o_valid,
    output dcrmc_pkg::t_item     o_item,
    input  logic                 i_take
);
    localparam int unsigned PW = $clog2(dcrmc_pkg::QDEPTH);

    dcrmc_pkg::t_item r_q [dcrmc_pkg::QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    dcrmc_pkg::t_item w_item;
    logic w_push, w_pop;

    always_comb begin
        w_item.kind      = i_kind;
        w_item.now       = i_now;
        w_item.awake     = i_awake;
        // an unused event code counts as nothing
        w_item.rx_event  = (i_rx_event == 2'd3) ? dcrmc_pkg::RX_NONE : i_rx_event;
        w_item.receiving = i_receiving;
        w_item.header    = i_header;
        w_item.hash      = dcrmc_pkg::fold_id(i_sender_id);
        w_item.strength  = i_strength;
        w_item.rnd       = i_rnd;
        w_item.accepted  = i_accepted;
        w_item.prio      = i_prio;
        w_item.budget    = i_budget;
    end

    assign full    = (r_cnt == (PW+1)'(dcrmc_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_push && !full;
    assign w_pop   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end
endmodule

// ----- sv/dcrmc_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module dcrmc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [31:0] r_q;
    logic [16:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [16:0] w_sh;
    logic [16:0] w_sub;

    assign w_sh   = {r_rem[15:0], r_q[31]};
    assign w_sub  = w_sh - {1'b0, i_den};
    assign o_quot = r_q;
    assign o_done = r_busy && (r_cnt == 6'(dcrmc_pkg::DIV_STEPS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
        end else if (r_busy && !o_done) begin
            if (!w_sub[16]) begin
                r_rem <= w_sub;
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[30:0], 1'b0};
            end
        end
    end
endmodule

// ----- sv/dcrmc_back.sv -----
// back end: mode logic, seen-map memory, job bookkeeping and result register
module dcrmc_back #(
    parameter int unsigned HOLD_TICKS    = dcrmc_pkg::HOLD_TICKS_DEF,
    parameter int unsigned MAX_JOB_TICKS = dcrmc_pkg::MAX_JOB_TICKS_DEF,
    parameter int unsigned JITTER_TICKS  = dcrmc_pkg::JITTER_TICKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  dcrmc_pkg::t_item  i_item,
    output logic              o_take,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    output logic              o_res_valid,
    output dcrmc_pkg::t_result o_res,
    input  logic              i_res_pop
);
    // configuration
    logic        r_rx_en, r_rx_cont;
    logic signed [7:0] r_thresh;
    logic [15:0] r_short, r_long, r_off, r_slot, r_quiet;

    // controller state
    dcrmc_pkg::t_mac_mode r_mode, n_mode;
    logic        r_entered, n_entered;
    logic        r_radio, n_radio;
    logic [31:0] r_tstart, n_tstart;
    logic [31:0] r_wait, n_wait;
    logic        r_jit, n_jit;
    logic [7:0]  r_other, n_other;
    logic [7:0]  r_sent, n_sent;
    logic [15:0] r_limit, n_limit;
    logic [31:0] r_jstart, n_jstart;
    logic [3:0]  r_prio, n_prio;
    logic        r_energy, n_energy;

    dcrmc_pkg::t_back_state r_st, n_st;
    dcrmc_pkg::t_result     r_res, n_res;
    logic                   r_rvalid, n_rvalid;

    // seen map: 32 bytes of eight sender bits, cleared as a whole on listen entry
    logic [7:0]             r_map [dcrmc_pkg::MAP_SIZE/8];
    logic [7:0]             r_map_byte;
    logic [4:0]             w_map_addr;
    logic [7:0]             w_map_bit;
    logic                   w_map_clr, w_map_set;
    logic                   w_fresh;

    logic        w_div_start, w_div_done;
    logic [31:0] w_quot;

    dcrmc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (i_item.budget),
        .i_den   (r_slot),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    logic [31:0] w_round;
    logic [23:0] w_round_full;
    assign w_round_full = ({16'd0, r_other} + 24'd1) * {8'd0, r_slot};
    assign w_round = {8'd0, w_round_full};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_en   <= 1'b0;
            r_rx_cont <= 1'b0;
            r_thresh  <= -8'sd90;
            r_short   <= 16'd5;
            r_long    <= 16'd50;
            r_off     <= 16'd100;
            r_slot    <= 16'd10;
            r_quiet   <= 16'd20;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dcrmc_pkg::CFG_RX_EN:   r_rx_en   <= i_cfg_data[0];
                dcrmc_pkg::CFG_RX_CONT: r_rx_cont <= i_cfg_data[0];
                dcrmc_pkg::CFG_THRESH:  r_thresh  <= i_cfg_data[7:0];
                dcrmc_pkg::CFG_SHORT:   r_short   <= i_cfg_data;
                dcrmc_pkg::CFG_LONG:    r_long    <= i_cfg_data;
                dcrmc_pkg::CFG_OFF:     r_off     <= i_cfg_data;
                dcrmc_pkg::CFG_SLOT:    r_slot    <= i_cfg_data;
                dcrmc_pkg::CFG_QUIET:   r_quiet   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a changed receive enable or continuous-receive bit restarts receive mode
    logic w_cfg_restart;
    assign w_cfg_restart = i_cfg_we && (r_mode == dcrmc_pkg::M_RX) &&
        (((i_cfg_idx == dcrmc_pkg::CFG_RX_EN) && (i_cfg_data[0] != r_rx_en)) ||
         ((i_cfg_idx == dcrmc_pkg::CFG_RX_CONT) && (i_cfg_data[0] != r_rx_cont)));

    function automatic logic elapsed(input logic [31:0] now, input logic [31:0] t0,
                                     input logic [31:0] span);
        logic [31:0] d;
        d = now - t0;
        elapsed = (d >= span);
    endfunction

    logic        w_busy_mode;
    logic        w_mark;
    logic [31:0] w_delay;
    logic [31:0] w_rxslot;
    logic [31:0] w_now;
    logic [31:0] w_lim;
    logic [7:0]  w_sent_inc;

    assign w_now       = i_item.now;
    assign w_busy_mode = (r_mode != dcrmc_pkg::M_RX);
    assign w_mark      = (i_item.rx_event == dcrmc_pkg::RX_FRAME) && i_item.header;
    assign w_delay     = r_jit ? 32'(JITTER_TICKS) : 32'd0;
    assign w_rxslot    = i_item.receiving ? {16'd0, r_slot} : 32'd0;
    assign w_sent_inc  = (i_item.accepted && (r_sent != 8'hFF)) ? r_sent + 8'd1 : r_sent;
    assign w_lim = (r_slot == 16'd0) ? 32'd65535 :
                   (w_quot > 32'd65535) ? 32'd65535 :
                   (w_quot == 32'd0) ? 32'd1 : w_quot;
    assign w_map_clr = (r_st == dcrmc_pkg::S_CLEAR);

    assign w_map_addr = i_item.hash[7:3];
    assign w_map_bit  = 8'd1 << i_item.hash[2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_map_clr) begin
            r_map <= '{default: '0};
        end else if (w_map_set) begin
            r_map[w_map_addr] <= r_map_byte | w_map_bit;
        end
    end

    // byte read during the lookup cycle, used by the mode logic in the cycle after
    always_ff @(posedge i_clk) begin
        r_map_byte <= r_map[w_map_addr];
    end

    assign w_fresh = !(|(r_map_byte & w_map_bit));

    assign w_map_set = (r_st == dcrmc_pkg::S_TICK) && w_mark &&
                       ((r_mode == dcrmc_pkg::M_LOOK) || (r_mode == dcrmc_pkg::M_TX));

    always_comb begin
        logic [31:0] ts, wt;
        logic        rw, ent, en, jt, fresh, jmp, sn, dl;
        logic [7:0]  oc, sc;
        logic [1:0]  ev;
        logic [31:0] rnd_round;
        ts = r_tstart; wt = r_wait; rw = r_radio; ent = r_entered; en = r_energy;
        jt = r_jit; oc = r_other; sc = r_sent; ev = dcrmc_pkg::EV_NONE;
        sn = 1'b0; dl = 1'b0; jmp = 1'b0; fresh = w_fresh;
        rnd_round = w_round;

        n_mode = r_mode; n_entered = r_entered; n_radio = r_radio;
        n_tstart = r_tstart; n_wait = r_wait; n_jit = r_jit; n_other = r_other;
        n_sent = r_sent; n_limit = r_limit; n_jstart = r_jstart; n_prio = r_prio;
        n_energy = r_energy; n_st = r_st; n_res = r_res; n_rvalid = r_rvalid;
        o_take = 1'b0; w_div_start = 1'b0;

        if (w_cfg_restart) n_entered = 1'b0;
        if (r_rvalid && i_res_pop) n_rvalid = 1'b0;

        unique case (r_st)
            dcrmc_pkg::S_IDLE: begin
                if (i_valid && !(r_rvalid && !i_res_pop)) begin
                    unique case (i_item.kind)
                        dcrmc_pkg::IN_REQ: begin
                            if (!w_busy_mode || i_item.prio >= r_prio) begin
                                w_div_start = 1'b1;
                                n_st = dcrmc_pkg::S_DIV;
                            end else begin
                                n_st = dcrmc_pkg::S_OUT;
                            end
                        end
                        dcrmc_pkg::IN_TICK: begin
                            if (r_mode == dcrmc_pkg::M_LOOK && !r_entered)
                                n_st = dcrmc_pkg::S_CLEAR;
                            else
                                n_st = dcrmc_pkg::S_MARK;
                        end
                        dcrmc_pkg::IN_IDLE: begin
                            n_mode = dcrmc_pkg::M_IDLE;
                            n_entered = 1'b0;
                            n_st = dcrmc_pkg::S_OUT;
                        end
                        default: n_st = dcrmc_pkg::S_OUT;
                    endcase
                end
            end
            dcrmc_pkg::S_CLEAR: begin
                n_other = 8'd0;
                n_st = dcrmc_pkg::S_MARK;
            end
            dcrmc_pkg::S_MARK: begin
                // map lookup registered into r_map_byte
                n_st = dcrmc_pkg::S_TICK;
            end
            dcrmc_pkg::S_DIV: begin
                if (w_div_done) begin
                    if (w_busy_mode)
                        ev = (i_item.prio == r_prio) ? dcrmc_pkg::EV_REPLACED
                                                     : dcrmc_pkg::EV_PREEMPT;
                    n_prio = i_item.prio;
                    n_limit = w_lim[15:0];
                    n_sent = 8'd0;
                    if (!w_busy_mode) begin
                        n_mode = dcrmc_pkg::M_LOOK;
                        n_entered = 1'b0;
                    end
                    n_jstart = w_now;
                    o_take = 1'b1;
                    n_rvalid = 1'b1;
                    n_res = '0;
                    n_res.radio_on = r_radio;
                    n_res.event_code = ev;
                    n_res.request_taken = 1'b1;
                    n_res.sent_count = 8'd0;
                    n_res.others_seen = r_other;
                    n_res.energy_latched = r_energy;
                    n_res.busy_res = 1'b1;
                    n_st = dcrmc_pkg::S_IDLE;
                end
            end
            dcrmc_pkg::S_OUT: begin
                o_take = 1'b1;
                n_rvalid = 1'b1;
                n_res = '0;
                n_res.radio_on = r_radio;
                n_res.sent_count = r_sent;
                n_res.others_seen = r_other;
                n_res.energy_latched = r_energy;
                n_res.busy_res = (n_mode != dcrmc_pkg::M_RX);
                n_st = dcrmc_pkg::S_IDLE;
            end
            dcrmc_pkg::S_TICK: begin
                unique case (r_mode)
                    dcrmc_pkg::M_RX: begin
                        if (!ent) begin
                            if (r_rx_en) begin
                                rw = 1'b1; ts = w_now; wt = {16'd0, r_long};
                            end else begin
                                rw = 1'b0;
                            end
                            en = 1'b0; ent = 1'b1;
                        end
                        if (!rw && r_rx_en && (elapsed(w_now, ts, wt) || i_item.awake)) begin
                            rw = 1'b1; ts = w_now; wt = {16'd0, r_short};
                        end
                        if (i_item.awake) begin
                            if (i_item.rx_event == dcrmc_pkg::RX_FRAME) begin
                                ts = w_now; wt = {16'd0, r_long}; dl = i_item.header;
                            end else if (i_item.rx_event == dcrmc_pkg::RX_CRC) begin
                                ts = w_now; wt = {16'd0, r_long};
                            end else if (!i_item.receiving && !r_rx_cont) begin
                                if (r_thresh != 8'sd0 && i_item.strength >= r_thresh) begin
                                    ts = w_now; wt = 32'(HOLD_TICKS); en = 1'b1;
                                end else if (elapsed(w_now, ts, wt)) begin
                                    rw = 1'b0; en = 1'b0; ts = w_now; wt = {16'd0, r_off};
                                end
                            end
                        end
                    end
                    dcrmc_pkg::M_LOOK: begin
                        if (!ent) begin
                            rw = 1'b1; ts = w_now; ent = 1'b1;
                            fresh = 1'b1; // map was just cleared
                        end
                        if (w_mark) begin
                            dl = r_rx_en;
                            if (fresh) begin
                                ts = w_now;
                                if (oc != 8'hFF) oc = oc + 8'd1;
                            end else begin
                                jmp = 1'b1;
                            end
                        end
                        rnd_round = 32'(({16'd0, oc} + 24'd1) * {8'd0, r_slot});
                        if (jmp || elapsed(w_now, ts, {16'd0, r_quiet} + w_rxslot)) begin
                            sn = 1'b1;
                            sc = w_sent_inc;
                            if ({8'd0, sc} < r_limit) begin
                                wt = rnd_round + (jmp ? {17'd0, r_slot[15:1]} : 32'd0);
                                ts = w_now;
                                n_mode = dcrmc_pkg::M_TX; ent = 1'b0;
                            end else begin
                                ev = dcrmc_pkg::EV_DONE;
                                n_mode = dcrmc_pkg::M_RX; ent = 1'b0;
                            end
                        end
                    end
                    dcrmc_pkg::M_TX: begin
                        logic [31:0] dly;
                        if (!ent) begin
                            jt = i_item.rnd; ent = 1'b1;
                        end
                        if (w_mark) begin
                            dl = r_rx_en;
                            if (fresh) begin
                                if (oc != 8'hFF) oc = oc + 8'd1;
                                wt = 32'(({16'd0, oc} + 24'd1) * {8'd0, r_slot});
                            end
                        end
                        rnd_round = 32'(({16'd0, oc} + 24'd1) * {8'd0, r_slot});
                        dly = jt ? 32'(JITTER_TICKS) : 32'd0;
                        if (elapsed(w_now, ts, wt + dly + w_rxslot)) begin
                            sn = 1'b1;
                            sc = w_sent_inc;
                            if ({8'd0, sc} < r_limit &&
                                (w_now - r_jstart) < 32'(MAX_JOB_TICKS)) begin
                                jt = i_item.rnd;
                                ts = w_now - dly;
                                wt = rnd_round;
                            end else begin
                                ev = dcrmc_pkg::EV_DONE;
                                n_mode = dcrmc_pkg::M_RX; ent = 1'b0;
                            end
                        end
                    end
                    default: begin
                        if (!ent) begin
                            rw = 1'b1; ts = w_now; wt = {16'd0, r_short}; ent = 1'b1;
                        end
                        if (!rw && elapsed(w_now, ts, wt)) begin
                            rw = 1'b1; ts = w_now; wt = {16'd0, r_short};
                        end
                        if (i_item.awake && elapsed(w_now, ts, wt)) begin
                            rw = 1'b0; ts = w_now; wt = {16'd0, r_off};
                        end
                    end
                endcase
                n_tstart = ts; n_wait = wt; n_radio = rw; n_entered = ent;
                n_energy = en; n_jit = jt; n_other = oc; n_sent = sc;
                o_take = 1'b1;
                n_rvalid = 1'b1;
                n_res.radio_on = rw;
                n_res.send_now = sn;
                n_res.frame_delivered = dl;
                n_res.event_code = ev;
                n_res.request_taken = 1'b0;
                n_res.sent_count = sc;
                n_res.others_seen = oc;
                n_res.energy_latched = en;
                n_res.busy_res = (n_mode != dcrmc_pkg::M_RX);
                n_st = dcrmc_pkg::S_IDLE;
            end
            default: n_st = dcrmc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= dcrmc_pkg::S_IDLE;
            r_mode   <= dcrmc_pkg::M_RX;
            r_entered <= 1'b0;
            r_radio  <= 1'b0;
            r_tstart <= '0;
            r_wait   <= '0;
            r_jit    <= 1'b0;
            r_other  <= '0;
            r_sent   <= '0;
            r_limit  <= '0;
            r_jstart <= '0;
            r_prio   <= '0;
            r_energy <= 1'b0;
            r_rvalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_mode   <= n_mode;
            r_entered <= n_entered;
            r_radio  <= n_radio;
            r_tstart <= n_tstart;
            r_wait   <= n_wait;
            r_jit    <= n_jit;
            r_other  <= n_other;
            r_sent   <= n_sent;
            r_limit  <= n_limit;
            r_jstart <= n_jstart;
            r_prio   <= n_prio;
            r_energy <= n_energy;
            r_rvalid <= n_rvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res_valid = r_rvalid;
    assign o_res       = r_res;
endmodule

// ----- sv/dcrmc_checker.sv -----
// port-level checker for the radio link controller, bound to the top level
module dcrmc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic       o_request_taken,
    input logic [1:0] o_event_code,
    input logic       o_send_now,
    input logic       o_busy_res
);
    // a waiting word stays until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty) else $error("result word dropped");

    // replace or preempt only comes with a taken request
    a_evreq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_event_code == dcrmc_pkg::EV_REPLACED ||
                    o_event_code == dcrmc_pkg::EV_PREEMPT)) |-> o_request_taken)
        else $error("preempt event without request");

    // a taken request leaves the transmitter busy
    a_reqbusy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_request_taken) |-> o_busy_res)
        else $error("request taken but not busy");

    // a send never coincides with a request result
    a_sendreq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_send_now) |-> !o_request_taken)
        else $error("send on request word");
endmodule

bind duty_cycled_radio_mac_controller dcrmc_checker u_dcrmc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .empty           (empty),
    .pop             (pop),
    .o_request_taken (o_request_taken),
    .o_event_code    (o_event_code),
    .o_send_now      (o_send_now),
    .o_busy_res      (o_busy_res)
);

// ----- bench/duty_cycled_radio_mac_controller_tb.sv -----
// testbench for the duty-cycled radio link controller: directed table, random phases, predictor
module duty_cycled_radio_mac_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dcrmc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 100;

    typedef struct {
        t_in_mode    mode;
        logic [31:0] now;
        logic        awake;
        logic [1:0]  rx_event;
        logic        receiving;
        logic        header;
        logic [31:0] sender;
        logic signed [7:0] strength;
        logic        rnd;
        logic        accepted;
        logic [3:0]  prio;
        logic [31:0] budget;
    } t_word;

    typedef struct {
        t_word   w;
        bit      typed;
        t_result res;
    } t_row;

    logic i_clk = 0, i_rst_n = 0, push = 0, pop = 0;
    logic full, empty;
    logic [1:0] i_mode = IN_TICK;
    logic [31:0] i_now = 0, i_sender_id = 0, i_budget_ticks = 0;
    logic i_radio_awake = 0, i_receiving = 0, i_header_complete = 0;
    logic i_random_bit = 0, i_send_accepted = 0;
    logic [1:0] i_rx_event = RX_NONE;
    logic signed [7:0] i_signal_strength = 0;
    logic [3:0] i_priority_req = 0;
    logic o_radio_on, o_send_now, o_frame_delivered, o_request_taken;
    logic o_energy_latched, o_busy_res;
    logic [1:0] o_event_code;
    logic [7:0] o_sent_count, o_others_seen;
    logic i_cfg_we = 0;
    logic [2:0] i_cfg_idx = CFG_RX_EN;
    logic [15:0] i_cfg_data = 0;

    duty_cycled_radio_mac_controller DUT (.*);

    // predictor state
    t_mac_mode  p_mode;
    bit         p_entered, p_radio, p_jit, p_energy;
    bit [31:0]  p_tstart, p_wait, p_jstart;
    bit [7:0]   p_others, p_sent;
    bit [15:0]  p_limit;
    bit [3:0]   p_prio;
    bit [255:0] p_seen;
    bit         c_rx_en, c_rx_cont;
    logic signed [7:0] c_thr;
    bit [15:0]  c_short, c_long, c_off, c_slot, c_quiet;

    t_result    result_q[$];
    int         cycles = 0, mismatches = 0, n_results = 0, n_items = 0;
    int         n_sends = 0, n_taken = 0, n_cfg = 0;
    bit         calm = 0;
    logic [31:0] tnow = 0;
    logic [31:0] id_pool[8];

    initial forever #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic bit span_over(logic [31:0] now, logic [31:0] span);
        return (now - p_tstart) >= span;
    endfunction

    function automatic logic [31:0] round_ticks();
        return (32'(p_others) + 32'd1) * 32'(c_slot);
    endfunction

    function automatic bit note_sender(logic [31:0] id);
        logic [7:0] h;
        bit fresh;
        h = id[31:24] ^ id[23:16] ^ id[15:8] ^ id[7:0];
        fresh = !p_seen[h];
        p_seen[h] = 1'b1;
        if (fresh && p_others < 8'd255) p_others++;
        return fresh;
    endfunction

    task automatic ctl_reset();
        c_rx_en = 0; c_rx_cont = 0; c_thr = -8'sd90;
        c_short = 5; c_long = 50; c_off = 100; c_slot = 10; c_quiet = 20;
        p_mode = M_RX; p_entered = 0; p_radio = 0; p_tstart = 0; p_wait = 0;
        p_jit = 0; p_seen = '0; p_others = 0; p_sent = 0; p_limit = 0;
        p_jstart = 0; p_prio = 0; p_energy = 0;
    endtask

    task automatic ctl_write(logic [2:0] idx, logic [15:0] d);
        case (idx)
            CFG_RX_EN: begin
                if (d[0] != c_rx_en && p_mode == M_RX) p_entered = 0;
                c_rx_en = d[0];
            end
            CFG_RX_CONT: begin
                if (d[0] != c_rx_cont && p_mode == M_RX) p_entered = 0;
                c_rx_cont = d[0];
            end
            CFG_THRESH: c_thr = d[7:0];
            CFG_SHORT:  c_short = d;
            CFG_LONG:   c_long = d;
            CFG_OFF:    c_off = d;
            CFG_SLOT:   c_slot = d;
            CFG_QUIET:  c_quiet = d;
            default: ;
        endcase
    endtask

    function automatic t_result ctl_predict(t_word w);
        t_result r;
        bit busy, jump;
        logic [31:0] lim, delay;
        r = '0;
        jump = 0;
        if (w.mode == IN_REQ) begin
            busy = p_mode != M_RX;
            if (!busy || w.prio >= p_prio) begin
                if (busy) r.event_code = (w.prio == p_prio) ? EV_REPLACED : EV_PREEMPT;
                p_prio = w.prio;
                lim = (c_slot == 0) ? 32'd65535 : w.budget / 32'(c_slot);
                if (lim > 32'd65535) lim = 32'd65535;
                if (lim == 0) lim = 1;
                p_limit = lim[15:0];
                p_sent = 0;
                if (!busy) begin p_mode = M_LOOK; p_entered = 0; end
                p_jstart = w.now;
                r.request_taken = 1;
            end
        end else if (w.mode == IN_IDLE) begin
            p_mode = M_IDLE; p_entered = 0;
        end else if (w.mode == IN_TICK) begin
            case (p_mode)
                M_RX: begin
                    if (!p_entered) begin
                        if (c_rx_en) begin
                            p_radio = 1; p_tstart = w.now; p_wait = 32'(c_long);
                        end else begin
                            p_radio = 0;
                        end
                        p_energy = 0; p_entered = 1;
                    end
                    if (!p_radio && c_rx_en && (span_over(w.now, p_wait) || w.awake)) begin
                        p_radio = 1; p_tstart = w.now; p_wait = 32'(c_short);
                    end
                    if (w.awake) begin
                        if (w.rx_event == RX_FRAME) begin
                            p_tstart = w.now; p_wait = 32'(c_long);
                            r.frame_delivered = w.header;
                        end else if (w.rx_event == RX_CRC) begin
                            p_tstart = w.now; p_wait = 32'(c_long);
                        end else if (!w.receiving && !c_rx_cont) begin
                            if (c_thr != 0 && w.strength >= c_thr) begin
                                p_tstart = w.now; p_wait = HOLD_TICKS_DEF; p_energy = 1;
                            end else if (span_over(w.now, p_wait)) begin
                                p_radio = 0; p_energy = 0;
                                p_tstart = w.now; p_wait = 32'(c_off);
                            end
                        end
                    end
                end
                M_LOOK: begin
                    if (!p_entered) begin
                        p_radio = 1; p_others = 0; p_tstart = w.now;
                        p_seen = '0; p_entered = 1;
                    end
                    if (w.rx_event == RX_FRAME && w.header) begin
                        r.frame_delivered = c_rx_en;
                        if (note_sender(w.sender)) p_tstart = w.now;
                        else jump = 1;
                    end
                    if (jump || span_over(w.now, 32'(c_quiet) +
                                          (w.receiving ? 32'(c_slot) : 32'd0))) begin
                        r.send_now = 1;
                        if (w.accepted && p_sent < 8'd255) p_sent++;
                        if (16'(p_sent) < p_limit) begin
                            p_wait = round_ticks() + (jump ? 32'(c_slot / 2) : 32'd0);
                            p_tstart = w.now;
                            p_mode = M_TX; p_entered = 0;
                        end else begin
                            r.event_code = EV_DONE;
                            p_mode = M_RX; p_entered = 0;
                        end
                    end
                end
                M_TX: begin
                    if (!p_entered) begin p_jit = w.rnd; p_entered = 1; end
                    if (w.rx_event == RX_FRAME && w.header) begin
                        r.frame_delivered = c_rx_en;
                        if (note_sender(w.sender)) p_wait = round_ticks();
                    end
                    delay = p_jit ? 32'(JITTER_TICKS_DEF) : 32'd0;
                    if (span_over(w.now, p_wait + delay +
                                  (w.receiving ? 32'(c_slot) : 32'd0))) begin
                        r.send_now = 1;
                        if (w.accepted && p_sent < 8'd255) p_sent++;
                        if (16'(p_sent) < p_limit &&
                            (w.now - p_jstart) < 32'(MAX_JOB_TICKS_DEF)) begin
                            p_jit = w.rnd;
                            p_tstart = w.now - delay;
                            p_wait = round_ticks();
                        end else begin
                            r.event_code = EV_DONE;
                            p_mode = M_RX; p_entered = 0;
                        end
                    end
                end
                default: begin
                    if (!p_entered) begin
                        p_radio = 1; p_tstart = w.now; p_wait = 32'(c_short); p_entered = 1;
                    end
                    if (!p_radio && span_over(w.now, p_wait)) begin
                        p_radio = 1; p_tstart = w.now; p_wait = 32'(c_short);
                    end
                    if (w.awake && span_over(w.now, p_wait)) begin
                        p_radio = 0; p_tstart = w.now; p_wait = 32'(c_off);
                    end
                end
            endcase
        end
        r.radio_on = p_radio;
        r.sent_count = p_sent;
        r.others_seen = p_others;
        r.energy_latched = p_energy;
        r.busy_res = p_mode != M_RX;
        return r;
    endfunction

    function automatic t_word tick_word(logic [31:0] now, bit awake, logic [1:0] ev,
                                        bit recv, bit hdr, logic [31:0] sid,
                                        logic signed [7:0] str, bit rnd, bit acc);
        t_word w;
        w = '{mode: IN_TICK, now: now, awake: awake, rx_event: ev, receiving: recv,
              header: hdr, sender: sid, strength: str, rnd: rnd, accepted: acc,
              prio: 4'd0, budget: 32'd0};
        return w;
    endfunction

    function automatic t_word cmd_word(t_in_mode m, logic [31:0] now, logic [3:0] prio,
                                       logic [31:0] budget);
        t_word w;
        w = tick_word(now, 0, RX_NONE, 0, 0, 0, 0, 0, 0);
        w.mode = m; w.prio = prio; w.budget = budget;
        return w;
    endfunction

    function automatic t_word random_word(bit allow_idle);
        t_word w;
        int pick;
        pick = $urandom_range(0, 99);
        tnow = tnow + ((pick < 4) ? $urandom : $urandom_range(0, 30));
        w.now = tnow;
        pick = $urandom_range(0, 99);
        if (allow_idle && pick < 3) w.mode = IN_IDLE;
        else if (pick < 12) w.mode = IN_REQ;
        else if (pick < 16) w.mode = IN_NOP;
        else w.mode = IN_TICK;
        w.awake = $urandom_range(0, 9) < 7;
        pick = $urandom_range(0, 9);
        w.rx_event = (pick < 6) ? RX_NONE : (pick < 8) ? RX_FRAME : (pick < 9) ? RX_CRC : 2'd3;
        w.receiving = $urandom_range(0, 4) == 0;
        w.header = $urandom_range(0, 4) != 0;
        w.sender = ($urandom_range(0, 9) < 7) ? id_pool[$urandom_range(0, 7)] : $urandom;
        w.strength = 8'($urandom);
        w.rnd = 1'($urandom);
        w.accepted = $urandom_range(0, 4) != 0;
        w.prio = 4'($urandom);
        w.budget = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 80) : $urandom;
        return w;
    endfunction

    function automatic int gap_draw();
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    // one word into the block, then its expectation onto the queue
    task automatic send_word(t_word w, bit typed, t_result res);
        int gap;
        bit f;
        gap = gap_draw();
        if (gap > 0) begin
            push <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_mode <= w.mode; i_now <= w.now; i_radio_awake <= w.awake;
        i_rx_event <= w.rx_event; i_receiving <= w.receiving;
        i_header_complete <= w.header; i_sender_id <= w.sender;
        i_signal_strength <= w.strength; i_random_bit <= w.rnd;
        i_send_accepted <= w.accepted; i_priority_req <= w.prio;
        i_budget_ticks <= w.budget;
        push <= 1;
        do begin
            @(negedge i_clk);
            f = full;
            @(posedge i_clk);
        end while (f);
        begin
            t_result p;
            p = ctl_predict(w);
            result_q.push_back(typed ? res : p);
            n_items++;
            n_sends += p.send_now;
            n_taken += p.request_taken;
        end
    endtask

    // block must be idle: wait out every result plus pipeline drain
    task automatic settle();
        push <= 0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] d);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= d;
        ctl_write(idx, d);
        n_cfg++;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] span_draw(int phase);
        if (phase == 0) return 16'd1;
        if (phase == 1) return 16'hFFFF;
        return ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535))
                                           : 16'($urandom_range(1, 40));
    endfunction

    // receiver: stall a random while per word
    initial begin
        int gap;
        bit e;
        @(posedge i_rst_n);
        forever begin
            gap = gap_draw();
            if (gap > 0) begin
                pop <= 0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1;
            do begin
                @(negedge i_clk);
                e = empty;
                @(posedge i_clk);
            end while (e);
        end
    end

    // result check at the falling edge, ahead of the accepting rising edge
    always @(negedge i_clk) begin
        t_result got, want;
        if (i_rst_n && pop && !empty) begin
            got = '{o_radio_on, o_send_now, o_frame_delivered, o_event_code,
                    o_request_taken, o_sent_count, o_others_seen, o_energy_latched,
                    o_busy_res};
            n_results++;
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %p", got);
            end else begin
                want = result_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at word %0d: expected %p got %p",
                                 n_results, want, got);
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_result r;
        int pk;
        foreach (id_pool[k]) id_pool[k] = $urandom;
        ctl_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // directed table, typed results where obvious
        r = '0;
        rows.push_back('{tick_word(0, 0, RX_NONE, 0, 0, 0, 0, 0, 0), 1, r});
        rows.push_back('{cmd_word(IN_NOP, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF), 1, r});
        rows.push_back('{tick_word(1, 1, 2'd3, 0, 1, 32'hFFFF_FFFF, -8'sd128, 1, 1), 0, r});
        r.busy_res = 1; r.request_taken = 1;
        rows.push_back('{cmd_word(IN_REQ, 2, 4'd8, 0), 1, r});
        r.request_taken = 0;
        rows.push_back('{cmd_word(IN_REQ, 3, 4'd3, 100), 1, r});
        r.request_taken = 1; r.event_code = EV_REPLACED;
        rows.push_back('{cmd_word(IN_REQ, 4, 4'd8, 50), 1, r});
        r.event_code = EV_PREEMPT;
        rows.push_back('{cmd_word(IN_REQ, 5, 4'hF, 32'hFFFF_FFFF), 1, r});
        rows.push_back('{tick_word(10, 1, RX_FRAME, 0, 1, 32'h0102_0304, 0, 0, 1), 0, r});
        rows.push_back('{tick_word(11, 1, RX_FRAME, 0, 1, 32'h0102_0304, 0, 1, 1), 0, r});
        rows.push_back('{tick_word(12, 1, RX_FRAME, 1, 1, 32'hFFFF_FFFF, 127, 0, 0), 0, r});
        rows.push_back('{tick_word(40, 1, RX_CRC, 1, 0, 0, 0, 1, 1), 0, r});
        rows.push_back('{tick_word(100, 0, RX_NONE, 0, 0, 0, 0, 0, 1), 0, r});
        rows.push_back('{tick_word(200, 1, RX_FRAME, 0, 0, 32'h5A5A_A5A5, 0, 1, 1), 0, r});
        rows.push_back('{tick_word(6000, 1, RX_NONE, 0, 0, 0, 0, 0, 1), 0, r});
        rows.push_back('{tick_word(6001, 1, RX_NONE, 0, 0, 0, 127, 0, 0), 0, r});
        rows.push_back('{tick_word(32'hFFFF_FFF0, 1, RX_FRAME, 0, 1, 0, -8'sd90, 0, 0), 0, r});
        rows.push_back('{tick_word(32'h0000_0100, 1, RX_NONE, 0, 0, 0, 0, 0, 0), 0, r});
        foreach (rows[k]) send_word(rows[k].w, rows[k].typed, rows[k].res);
        tnow = 32'h0000_0200;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            calm = (ph % 3) == 2;
            write_reg(CFG_RX_EN, (ph == 0) ? 16'd0 : (ph == 1) ? 16'd1 : 16'($urandom));
            write_reg(CFG_RX_CONT, (ph == 0) ? 16'd0 : (ph == 1) ? 16'd1 : 16'($urandom_range(0, 3) == 0));
            pk = $urandom_range(0, 3);
            write_reg(CFG_THRESH, (ph == 0) ? 16'h0080 : (ph == 1) ? 16'h007F :
                                  (pk == 0) ? 16'h0000 : 16'($urandom));
            write_reg(CFG_SHORT, span_draw(ph));
            write_reg(CFG_LONG, span_draw(ph));
            write_reg(CFG_OFF, span_draw(ph));
            write_reg(CFG_SLOT, span_draw(ph));
            write_reg(CFG_QUIET, span_draw(ph));
            i_cfg_we <= 0;
            repeat (PHASE_ITEMS) send_word(random_word(0), 0, '0);
        end

        // forced idle is permanent, so it closes the run
        calm = 0;
        send_word(cmd_word(IN_REQ, tnow, 4'd2, 40), 0, '0);
        send_word(cmd_word(IN_IDLE, tnow, 0, 0), 0, '0);
        send_word(cmd_word(IN_REQ, tnow, 4'd1, 40), 0, '0);
        send_word(cmd_word(IN_REQ, tnow, 4'd9, 40), 0, '0);
        repeat (40) send_word(random_word(1), 0, '0);

        push <= 0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("%0d words in, %0d results checked, %0d register writes", n_items,
                 n_results, n_cfg);
        $display("%0d sends predicted, %0d requests taken, %0d mismatches", n_sends,
                 n_taken, mismatches);
        if (mismatches == 0 && result_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ----- sim.f -----
sv/dcrmc_pkg.sv
sv/dcrmc_front.sv
sv/dcrmc_div.sv
sv/dcrmc_back.sv
sv/duty_cycled_radio_mac_controller.sv
sv/dcrmc_checker.sv
bench/duty_cycled_radio_mac_controller_tb.sv
